// ===== rtl/nlv_pkg.sv =====
package nlv_pkg;

    // Parse phases; codes 9 to 15 are unused and behave as rejected
    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_SIGN    = 4'd1,
        PH_INT     = 4'd2,
        PH_POINT   = 4'd3,
        PH_FRAC    = 4'd4,
        PH_EXP     = 4'd5,
        PH_EXPSIGN = 4'd6,
        PH_EXPDIG  = 4'd7,
        PH_REJECT  = 4'd8
    } phase_t;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_LOW_E = 8'h65;
    localparam logic [7:0] CHAR_UP_E  = 8'h45;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Result handed from the parser to the output register
    typedef struct packed {
        logic valid;
        logic ok;
    } result_t;

    // One step of the literal grammar
    function automatic phase_t next_phase(input phase_t ph, input logic [7:0] c);
        logic dig;
        logic sgn;
        logic expc;
        logic pnt;
        phase_t nxt;
        dig  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        sgn  = (c == CHAR_MINUS) || (c == CHAR_PLUS);
        expc = (c == CHAR_LOW_E) || (c == CHAR_UP_E);
        pnt  = (c == CHAR_POINT);
        nxt  = PH_REJECT;
        case (ph)
            PH_START:
            begin
                if (sgn)      nxt = PH_SIGN;
                else if (dig) nxt = PH_INT;
                else if (pnt) nxt = PH_POINT;
            end
            PH_SIGN:
            begin
                if (dig)      nxt = PH_INT;
                else if (pnt) nxt = PH_POINT;
            end
            PH_INT:
            begin
                if (dig)       nxt = PH_INT;
                else if (pnt)  nxt = PH_FRAC;
                else if (expc) nxt = PH_EXP;
            end
            PH_POINT:
            begin
                if (dig) nxt = PH_FRAC;
            end
            PH_FRAC:
            begin
                if (dig)       nxt = PH_FRAC;
                else if (expc) nxt = PH_EXP;
            end
            PH_EXP:
            begin
                if (sgn)      nxt = PH_EXPSIGN;
                else if (dig) nxt = PH_EXPDIG;
            end
            PH_EXPSIGN, PH_EXPDIG:
            begin
                if (dig) nxt = PH_EXPDIG;
            end
            default:
            begin
                nxt = PH_REJECT;
            end
        endcase
        return nxt;
    endfunction

    function automatic logic is_accepting(input phase_t ph);
        return (ph == PH_INT) || (ph == PH_FRAC) || (ph == PH_EXPDIG);
    endfunction

endpackage

// ===== rtl/nlv_parser.sv =====
module nlv_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        char_code,
    input  logic              is_last,
    output nlv_pkg::result_t  res,
    input  logic              res_ready
);

    logic             in_valid_reg;
    logic [7:0]       char_reg;
    logic             last_reg;
    nlv_pkg::phase_t  phase_reg;
    nlv_pkg::phase_t  phase_next;
    nlv_pkg::phase_t  ph_step;
    logic             take_in;
    logic             advance;

    // Grammar step on the registered byte
    assign ph_step = nlv_pkg::next_phase(phase_reg, char_reg);

    // Non-last bytes never wait; a last byte waits for room in the output register
    assign advance  = in_valid_reg && (!last_reg || res_ready);
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    assign res.valid = in_valid_reg && last_reg;
    assign res.ok    = nlv_pkg::is_accepting(ph_step);

    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            phase_next = last_reg ? nlv_pkg::PH_START : ph_step;
        end
    end

    // Input register and phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= nlv_pkg::PH_START;
        end
        else
        begin
            phase_reg <= phase_next;
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            char_reg <= char_code;
            last_reg <= is_last;
        end
    end

endmodule

// ===== rtl/nlv_out.sv =====
module nlv_out (
    input  logic              clk,
    input  logic              rst_n,
    input  nlv_pkg::result_t  res,
    output logic              res_ready,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              literal_ok
);

    logic out_valid_reg;
    logic ok_reg;

    // Room when empty or when the held transaction leaves this cycle
    assign res_ready  = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign literal_ok = ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            ok_reg <= res.ok;
        end
    end

endmodule

// ===== rtl/numeric_literal_validator_top.sv =====
// A result passes through the input register, then the result register, after its last byte
// is accepted; a stalled result register can hold it back in the input register.
// Throughput: one byte per cycle while the input is not stalled; the phase update is one table step per byte.
// The input stalls only while a last byte waits behind a stalled result.
// Reset (rst_n, asynchronous, active low) empties both registers and returns
// the parse phase to the start of a literal.
module numeric_literal_validator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       literal_ok
);

    nlv_pkg::result_t res;
    logic             res_ready;

    nlv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .is_last   (is_last),
        .res       (res),
        .res_ready (res_ready)
    );

    nlv_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .res_ready  (res_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .literal_ok (literal_ok)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 2000;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] char_code = 8'h00;
    logic       is_last   = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       literal_ok;

    // Model state and expected verdicts
    nlv_pkg::phase_t lit_phase = nlv_pkg::PH_START;
    nlv_pkg::phase_t lit_phase_nxt;
    logic       verdict_due[$];
    logic       verdict_got;
    logic [7:0] lit_bytes[$];
    int         bytes_sent  = 0;
    int         error_count = 0;
    int         idle_cycles = 0;
    bit         quiet       = 1'b0;

    numeric_literal_validator_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .literal_ok (literal_ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Grammar step: classify the byte, then move the phase
    function automatic nlv_pkg::phase_t phase_after_byte(input nlv_pkg::phase_t ph,
                                                         input logic [7:0] c);
        logic digit;
        logic sign;
        logic point;
        logic expo;
        digit = (c >= nlv_pkg::CHAR_ZERO) && (c <= nlv_pkg::CHAR_NINE);
        sign  = (c == nlv_pkg::CHAR_PLUS) || (c == nlv_pkg::CHAR_MINUS);
        point = (c == nlv_pkg::CHAR_POINT);
        expo  = (c == nlv_pkg::CHAR_LOW_E) || (c == nlv_pkg::CHAR_UP_E);
        case (ph)
            nlv_pkg::PH_START:
                return sign ? nlv_pkg::PH_SIGN : digit ? nlv_pkg::PH_INT :
                       point ? nlv_pkg::PH_POINT : nlv_pkg::PH_REJECT;
            nlv_pkg::PH_SIGN:
                return digit ? nlv_pkg::PH_INT : point ? nlv_pkg::PH_POINT :
                       nlv_pkg::PH_REJECT;
            nlv_pkg::PH_INT:
                return digit ? nlv_pkg::PH_INT : point ? nlv_pkg::PH_FRAC :
                       expo ? nlv_pkg::PH_EXP : nlv_pkg::PH_REJECT;
            nlv_pkg::PH_POINT:
                return digit ? nlv_pkg::PH_FRAC : nlv_pkg::PH_REJECT;
            nlv_pkg::PH_FRAC:
                return digit ? nlv_pkg::PH_FRAC : expo ? nlv_pkg::PH_EXP :
                       nlv_pkg::PH_REJECT;
            nlv_pkg::PH_EXP:
                return sign ? nlv_pkg::PH_EXPSIGN : digit ? nlv_pkg::PH_EXPDIG :
                       nlv_pkg::PH_REJECT;
            nlv_pkg::PH_EXPSIGN:
                return digit ? nlv_pkg::PH_EXPDIG : nlv_pkg::PH_REJECT;
            nlv_pkg::PH_EXPDIG:
                return digit ? nlv_pkg::PH_EXPDIG : nlv_pkg::PH_REJECT;
            default:
                return nlv_pkg::PH_REJECT;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Follow accepted bytes and check each returned verdict
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                lit_phase_nxt = phase_after_byte(lit_phase, char_code);
                if (is_last)
                begin
                    verdict_due.push_back(lit_phase_nxt == nlv_pkg::PH_INT ||
                                          lit_phase_nxt == nlv_pkg::PH_FRAC ||
                                          lit_phase_nxt == nlv_pkg::PH_EXPDIG);
                    lit_phase = nlv_pkg::PH_START;
                end
                else
                begin
                    lit_phase = lit_phase_nxt;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (verdict_due.size() == 0)
                begin
                    report_mismatch("verdict with no literal pending");
                end
                else
                begin
                    verdict_got = verdict_due.pop_front();
                    if (literal_ok !== verdict_got)
                        report_mismatch($sformatf("literal_ok %b, expected %b",
                                                  literal_ok, verdict_got));
                end
            end
        end
    end

    // Receiver side stalls at random unless quiet
    always @(posedge clk)
    begin
        out_stall <= (!quiet && rst_n) ? ($urandom_range(99) < 15) : 1'b0;
    end

    // Watchdog: too long with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one byte and wait until it is taken
    task automatic send_byte(input logic [7:0] c, input logic last);
        while (!quiet && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        is_last   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_lit_bytes();
        for (int i = 0; i < lit_bytes.size(); i++)
            send_byte(lit_bytes[i], i == lit_bytes.size() - 1);
    endtask

    function automatic logic [7:0] grammar_char();
        case ($urandom_range(6))
            0:       return nlv_pkg::CHAR_MINUS;
            1:       return nlv_pkg::CHAR_PLUS;
            2:       return nlv_pkg::CHAR_POINT;
            3:       return nlv_pkg::CHAR_LOW_E;
            4:       return nlv_pkg::CHAR_UP_E;
            default: return nlv_pkg::CHAR_ZERO + 8'($urandom_range(9));
        endcase
    endfunction

    function automatic logic [7:0] digit_char();
        return nlv_pkg::CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    // Mostly well-formed literals, some corrupted, the rest noise
    task automatic build_literal();
        int kind;
        int pos;
        lit_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            if ($urandom_range(1))
                lit_bytes.push_back($urandom_range(1) ? nlv_pkg::CHAR_MINUS : nlv_pkg::CHAR_PLUS);
            repeat ($urandom_range(3)) lit_bytes.push_back(digit_char());
            if ($urandom_range(1))
            begin
                lit_bytes.push_back(nlv_pkg::CHAR_POINT);
                repeat ($urandom_range(3)) lit_bytes.push_back(digit_char());
            end
            if ($urandom_range(99) < 40)
            begin
                lit_bytes.push_back($urandom_range(1) ? nlv_pkg::CHAR_LOW_E : nlv_pkg::CHAR_UP_E);
                if ($urandom_range(1))
                    lit_bytes.push_back($urandom_range(1) ? nlv_pkg::CHAR_MINUS :
                                                            nlv_pkg::CHAR_PLUS);
                repeat ($urandom_range(2)) lit_bytes.push_back(digit_char());
            end
            if (lit_bytes.size() == 0)
                lit_bytes.push_back(digit_char());
            if (kind < 15)
            begin
                pos = $urandom_range(lit_bytes.size() - 1);
                lit_bytes[pos] = $urandom_range(1) ? 8'($urandom_range(255)) : grammar_char();
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                lit_bytes.push_back($urandom_range(1) ? 8'($urandom_range(255)) : grammar_char());
        end
    endtask

    task automatic wait_for_verdicts();
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_due.size() != 0)
            @(posedge clk);
    endtask

    // Digit edges, each phase, lone sign or point, bare exponent, stray sign, odd bytes
    task automatic test_directed_literals();
        send_text("0");
        send_text("-9");
        send_text("+.5");
        send_text("1.");
        send_text(".");
        send_text("+");
        send_text("-.");
        send_text("1e");
        send_text("3E+");
        send_text("4e-7");
        send_text("1-");
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_random_literals(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            build_literal();
            send_lit_bytes();
        end
    endtask

    // Sender holds off until every verdict is back, then resumes
    task automatic test_pause_for_results();
        repeat (5)
        begin
            build_literal();
            send_lit_bytes();
        end
        wait_for_verdicts();
        repeat (5)
        begin
            build_literal();
            send_lit_bytes();
        end
    endtask

    // Full rate on both sides
    task automatic test_back_to_back(input int n_bytes);
        quiet = 1'b1;
        test_random_literals(n_bytes);
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_literals();
        test_random_literals(850);
        test_pause_for_results();
        test_back_to_back(300);
        test_random_literals(50);

        wait_for_verdicts();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nlv_pkg.sv
rtl/nlv_parser.sv
rtl/nlv_out.sv
rtl/numeric_literal_validator_top.sv
bench/tb.sv
